/* src/piecewise_linear_transfer_lookup_unit_macros.svh */
// Assertion macros for the transfer function lookup unit
`ifndef PIECEWISE_LINEAR_TRANSFER_LOOKUP_UNIT_MACROS_SVH
`define PIECEWISE_LINEAR_TRANSFER_LOOKUP_UNIT_MACROS_SVH
// implication checked on every edge outside reset
`define PLT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m failed");
// next-cycle implication
`define PLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* src/pltl_pkg.sv */
// Shared types and constants for the transfer function lookup unit
package pltl_pkg;
    localparam int TableDepth   = 256;
    localparam int IdxBits      = 8;
    localparam int CntBits      = 9;
    localparam int FracBits     = 12;
    localparam int ChanBits     = 16;
    localparam int SampBits     = 16;
    localparam int DivBits      = SampBits + IdxBits + FracBits; // 36-bit dividend

    localparam logic [1:0] FUNC_WR_COLOR   = 2'd0;
    localparam logic [1:0] FUNC_WR_OPACITY = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP     = 2'd2;
    localparam logic [1:0] FUNC_IGNORED    = 2'd3;

    localparam logic [1:0] CFG_RANGE_LOW     = 2'd0;
    localparam logic [1:0] CFG_RANGE_HIGH    = 2'd1;
    localparam logic [1:0] CFG_COLOR_COUNT   = 2'd2;
    localparam logic [1:0] CFG_OPACITY_COUNT = 2'd3;

    typedef struct packed {
        logic [1:0]          func;
        logic [IdxBits-1:0]  entry_index;
        logic [ChanBits-1:0] red_in;
        logic [ChanBits-1:0] green_in;
        logic [ChanBits-1:0] blue_in;
        logic [ChanBits-1:0] alpha_in;
        logic [SampBits-1:0] sample;
        logic                sample_invalid;
    } req_t;

    typedef struct packed {
        logic [ChanBits-1:0] red_out;
        logic [ChanBits-1:0] green_out;
        logic [ChanBits-1:0] blue_out;
        logic [ChanBits-1:0] alpha_out;
    } rsp_t;

    // per-table position: lower/upper entry and blend weight
    typedef struct packed {
        logic [IdxBits-1:0]  lo;
        logic [IdxBits-1:0]  hi;
        logic [FracBits-1:0] frac;
    } pos_t;

    // control flags carried alongside a lookup
    typedef struct packed {
        logic invalid;
        logic color_empty;
        logic opacity_empty;
    } flags_t;

    // table write carried down to the RAM stage; opacity uses the low channel
    typedef struct packed {
        logic                  color;
        logic                  opacity;
        logic [IdxBits-1:0]    index;
        logic [3*ChanBits-1:0] data;
    } wr_t;
endpackage

/* src/pltl_ram.sv */
// Generic single-write, single-read RAM with registered read
module pltl_ram #(
    parameter int Width = 16,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* src/pltl_div.sv */
// Pipelined restoring divider, one quotient bit per stage, stall-aware
module pltl_div (
    input  logic                             clk,
    input  logic                             en,
    input  logic [pltl_pkg::DivBits-1:0]     dividend,
    input  logic [pltl_pkg::SampBits-1:0]    divisor,
    output logic [pltl_pkg::DivBits-1:0]     quotient
);
    localparam int N = pltl_pkg::DivBits;
    localparam int D = pltl_pkg::SampBits;

    logic [N-1:0] num_reg [N+1];
    logic [D:0]   rem_reg [N+1];
    logic [D-1:0] den_reg [N+1];

    always_comb
    begin
        num_reg[0] = dividend;
        rem_reg[0] = '0;
        den_reg[0] = divisor;
    end

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [D+1:0] trial;
        logic [D:0]   rem_next;
        logic [N-1:0] num_next;
        logic [N-1:0] numr_reg;
        logic [D:0]   remr_reg;
        logic [D-1:0] denr_reg;
        always_comb
        begin
            trial = {rem_reg[k], num_reg[k][N-1]} - {2'b00, den_reg[k]};
            if (!trial[D+1])
            begin
                rem_next = trial[D:0];
                num_next = {num_reg[k][N-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[k][D-1:0], num_reg[k][N-1]};
                num_next = {num_reg[k][N-2:0], 1'b0};
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                numr_reg <= num_next;
                remr_reg <= rem_next;
                denr_reg <= den_reg[k];
            end
        end
        always_comb
        begin
            num_reg[k+1] = numr_reg;
            rem_reg[k+1] = remr_reg;
            den_reg[k+1] = denr_reg;
        end
    end

    assign quotient = num_reg[N];
endmodule

/* src/pltl_blend.sv */
// Two-stage linear blend of neighboring entries, truncating
module pltl_blend (
    input  logic                          clk,
    input  logic                          en,
    input  logic [pltl_pkg::ChanBits-1:0] a,
    input  logic [pltl_pkg::ChanBits-1:0] b,
    input  logic [pltl_pkg::FracBits-1:0] frac,
    output logic [pltl_pkg::ChanBits-1:0] y
);
    localparam int C = pltl_pkg::ChanBits;
    localparam int F = pltl_pkg::FracBits;

    logic [C+F:0] pa_reg, pb_reg;
    logic [C+F:0] sum_reg;
    logic [F:0]   wa;

    assign wa = (F+1)'(1 << F) - {1'b0, frac};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg  <= (C+F+1)'(a * wa);
            pb_reg  <= (C+F+1)'(b * {1'b0, frac});
            sum_reg <= pa_reg + pb_reg;
        end
    end

    assign y = sum_reg[F +: C];
endmodule

/* src/piecewise_linear_transfer_lookup_unit.sv */
// Pipeline from the accepting edge to out_valid: offset, product,
// 36-stage divider, locate, RAM read, 2-stage blend, output register.
// Throughput: one request per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// Reset: control registers and valid bits clear asynchronously; range_high resets
// to all ones, counts to zero. Table contents are undefined until written.
`include "piecewise_linear_transfer_lookup_unit_macros.svh"
module piecewise_linear_transfer_lookup_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pltl_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output pltl_pkg::rsp_t out_data,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_data
);
    localparam int N  = pltl_pkg::DivBits;
    localparam int IB = pltl_pkg::IdxBits;
    localparam int CB = pltl_pkg::ChanBits;
    localparam int FB = pltl_pkg::FracBits;
    localparam int SB = pltl_pkg::SampBits;
    // pipeline: s0 reg, product reg, N div stages, locate reg, ram reg, blend (2 regs), output reg
    // table writes travel with the lookups and hit the RAMs at the read stage

    logic [SB-1:0] range_low_reg, range_high_reg;
    logic [8:0]    color_count_reg, opacity_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg     <= '0;
            range_high_reg    <= '1;
            color_count_reg   <= '0;
            opacity_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pltl_pkg::CFG_RANGE_LOW:     range_low_reg     <= cfg_data;
                pltl_pkg::CFG_RANGE_HIGH:    range_high_reg    <= cfg_data;
                pltl_pkg::CFG_COLOR_COUNT:   color_count_reg   <= cfg_data[8:0];
                pltl_pkg::CFG_OPACITY_COUNT: opacity_count_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // saturated counts minus one (0..255)
    logic [8:0]    cn_sat, on_sat;
    logic [IB-1:0] cnm1, onm1;
    assign cn_sat = (color_count_reg > 9'(pltl_pkg::TableDepth)) ?
                    9'(pltl_pkg::TableDepth) : color_count_reg;
    assign on_sat = (opacity_count_reg > 9'(pltl_pkg::TableDepth)) ?
                    9'(pltl_pkg::TableDepth) : opacity_count_reg;
    assign cnm1 = IB'(cn_sat - 9'd1);
    assign onm1 = IB'(on_sat - 9'd1);

    logic adv;
    logic accept;
    assign adv    = !out_valid || out_ready;
    assign in_ready = adv;
    assign accept = in_valid && in_ready;

    // stage 0: clamp decision and difference
    typedef enum logic [2:0] {
        ZONE_MID  = 3'b001,
        ZONE_LOW  = 3'b010,
        ZONE_HIGH = 3'b100
    } zone_t;

    logic                 v0_reg;
    pltl_pkg::flags_t     f0_reg;
    zone_t                z0_reg;
    logic [SB-1:0]        diff0_reg, span0_reg;
    zone_t                z0_next;
    pltl_pkg::wr_t        w0_reg, w0_next;

    always_comb
    begin
        if (in_data.sample <= range_low_reg)
        begin
            z0_next = ZONE_LOW;
        end
        else if (in_data.sample >= range_high_reg)
        begin
            z0_next = ZONE_HIGH;
        end
        else
        begin
            z0_next = ZONE_MID;
        end
    end

    always_comb
    begin
        w0_next.color   = accept && (in_data.func == pltl_pkg::FUNC_WR_COLOR);
        w0_next.opacity = accept && (in_data.func == pltl_pkg::FUNC_WR_OPACITY);
        w0_next.index   = in_data.entry_index;
        if (in_data.func == pltl_pkg::FUNC_WR_COLOR)
        begin
            w0_next.data = {in_data.red_in, in_data.green_in, in_data.blue_in};
        end
        else
        begin
            w0_next.data = {{(2*CB){1'b0}}, in_data.alpha_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            w0_reg <= '0;
        end
        else if (adv)
        begin
            v0_reg <= accept && (in_data.func == pltl_pkg::FUNC_LOOKUP);
            w0_reg <= w0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f0_reg.invalid       <= in_data.sample_invalid;
            f0_reg.color_empty   <= (cn_sat == 9'd0);
            f0_reg.opacity_empty <= (on_sat == 9'd0);
            z0_reg    <= z0_next;
            diff0_reg <= in_data.sample - range_low_reg;
            span0_reg <= range_high_reg - range_low_reg;
        end
    end

    // stage 1: two products (sample offset times count-1), registered
    logic [SB+IB-1:0] cprod1_reg, oprod1_reg;
    logic [SB-1:0]    span1_reg;
    logic             v1_reg;
    pltl_pkg::flags_t f1_reg;
    zone_t            z1_reg;
    pltl_pkg::wr_t    w1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            w1_reg <= '0;
        end
        else if (adv)
        begin
            v1_reg <= v0_reg;
            w1_reg <= w0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cprod1_reg <= (SB+IB)'(diff0_reg * cnm1);
            oprod1_reg <= (SB+IB)'(diff0_reg * onm1);
            span1_reg  <= span0_reg;
            f1_reg     <= f0_reg;
            z1_reg     <= z0_reg;
        end
    end

    // dividers
    logic [N-1:0] cq, oq;
    pltl_div u_cdiv (
        .clk(clk), .en(adv),
        .dividend({cprod1_reg, FB'(0)}), .divisor(span1_reg), .quotient(cq)
    );
    pltl_div u_odiv (
        .clk(clk), .en(adv),
        .dividend({oprod1_reg, FB'(0)}), .divisor(span1_reg), .quotient(oq)
    );

    // side pipe for valid/flags/zone/writes across divider
    logic             vd_reg [N];
    pltl_pkg::flags_t fd_reg [N];
    zone_t            zd_reg [N];
    pltl_pkg::wr_t    wd_reg [N];

    for (genvar k = 0; k < N; k++)
    begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vd_reg[k] <= 1'b0;
                wd_reg[k] <= '0;
            end
            else if (adv)
            begin
                vd_reg[k] <= (k == 0) ? v1_reg : vd_reg[(k == 0) ? 0 : k-1];
                wd_reg[k] <= (k == 0) ? w1_reg : wd_reg[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                fd_reg[k] <= (k == 0) ? f1_reg : fd_reg[(k == 0) ? 0 : k-1];
                zd_reg[k] <= (k == 0) ? z1_reg : zd_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // locate
    function automatic pltl_pkg::pos_t locate(input zone_t z, input logic [N-1:0] q,
                                              input logic [IB-1:0] nm1);
        pltl_pkg::pos_t p;
        logic [N-FB-1:0] ix;
        p = '0;
        ix = q[N-1:FB];
        case (z)
            ZONE_LOW:
            begin
                p = '0;
            end
            ZONE_HIGH:
            begin
                p.lo = nm1;
                p.hi = nm1;
            end
            default:
            begin
                if (ix >= (N-FB)'(nm1))
                begin
                    p.lo = nm1;
                    p.hi = nm1;
                end
                else
                begin
                    p.lo = IB'(ix);
                    p.hi = IB'(ix) + IB'(1);
                end
                p.frac = q[FB-1:0];
            end
        endcase
        return p;
    endfunction

    pltl_pkg::pos_t   cpos, opos;
    assign cpos = locate(zd_reg[N-1], cq, cnm1);
    assign opos = locate(zd_reg[N-1], oq, onm1);

    // stage L: locate registered
    logic             vl_reg;
    pltl_pkg::flags_t fl_reg;
    pltl_pkg::pos_t   cpl_reg, opl_reg;
    pltl_pkg::wr_t    wl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vl_reg <= 1'b0;
            wl_reg <= '0;
        end
        else if (adv)
        begin
            vl_reg <= vd_reg[N-1];
            wl_reg <= wd_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fl_reg  <= fd_reg[N-1];
            cpl_reg <= cpos;
            opl_reg <= opos;
        end
    end

    // stage R: RAM reads (four ports via duplicated RAMs), writes in request order
    logic            cwe, owe;
    logic [3*CB-1:0] cra, crb;
    logic [CB-1:0]   oa, ob;
    assign cwe = adv && wl_reg.color;
    assign owe = adv && wl_reg.opacity;

    pltl_ram #(.Width(3*CB), .Depth(pltl_pkg::TableDepth)) u_cram_a (
        .clk(clk), .we(cwe), .waddr(wl_reg.index), .wdata(wl_reg.data),
        .re(adv), .raddr(cpl_reg.lo), .rdata(cra)
    );
    pltl_ram #(.Width(3*CB), .Depth(pltl_pkg::TableDepth)) u_cram_b (
        .clk(clk), .we(cwe), .waddr(wl_reg.index), .wdata(wl_reg.data),
        .re(adv), .raddr(cpl_reg.hi), .rdata(crb)
    );
    pltl_ram #(.Width(CB), .Depth(pltl_pkg::TableDepth)) u_oram_a (
        .clk(clk), .we(owe), .waddr(wl_reg.index), .wdata(wl_reg.data[CB-1:0]),
        .re(adv), .raddr(opl_reg.lo), .rdata(oa)
    );
    pltl_ram #(.Width(CB), .Depth(pltl_pkg::TableDepth)) u_oram_b (
        .clk(clk), .we(owe), .waddr(wl_reg.index), .wdata(wl_reg.data[CB-1:0]),
        .re(adv), .raddr(opl_reg.hi), .rdata(ob)
    );

    logic                vr_reg;
    pltl_pkg::flags_t    fr_reg;
    logic [FB-1:0]       cfr_reg, ofr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg <= 1'b0;
        end
        else if (adv)
        begin
            vr_reg <= vl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fr_reg  <= fl_reg;
            cfr_reg <= cpl_reg.frac;
            ofr_reg <= opl_reg.frac;
        end
    end

    // blend (two stages)
    logic [CB-1:0] br, bg, bb, ba;
    pltl_blend u_br (.clk(clk), .en(adv), .a(cra[3*CB-1:2*CB]), .b(crb[3*CB-1:2*CB]),
                     .frac(cfr_reg), .y(br));
    pltl_blend u_bg (.clk(clk), .en(adv), .a(cra[2*CB-1:CB]), .b(crb[2*CB-1:CB]),
                     .frac(cfr_reg), .y(bg));
    pltl_blend u_bb (.clk(clk), .en(adv), .a(cra[CB-1:0]), .b(crb[CB-1:0]),
                     .frac(cfr_reg), .y(bb));
    pltl_blend u_ba (.clk(clk), .en(adv), .a(oa), .b(ob), .frac(ofr_reg), .y(ba));

    logic             vb_reg [2];
    pltl_pkg::flags_t fb_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg[0] <= 1'b0;
            vb_reg[1] <= 1'b0;
        end
        else if (adv)
        begin
            vb_reg[0] <= vr_reg;
            vb_reg[1] <= vb_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fb_reg[0] <= fr_reg;
            fb_reg[1] <= fb_reg[0];
        end
    end

    // output register
    logic           out_valid_reg;
    pltl_pkg::rsp_t out_data_reg, out_data_next;

    always_comb
    begin
        out_data_next.red_out   = br;
        out_data_next.green_out = bg;
        out_data_next.blue_out  = bb;
        out_data_next.alpha_out = ba;
        if (fb_reg[1].color_empty)
        begin
            out_data_next.red_out   = '1;
            out_data_next.green_out = '1;
            out_data_next.blue_out  = '1;
        end
        if (fb_reg[1].opacity_empty)
        begin
            out_data_next.alpha_out = '1;
        end
        if (fb_reg[1].invalid)
        begin
            out_data_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vb_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `PLT_ASSERT_IMPL(a_stall_holds, out_valid && !out_ready, !in_ready)
    `PLT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, out_valid && $stable(out_data))
    `PLT_ASSERT_NEXT(a_no_write_result, !adv, $stable(vb_reg[1]))
endmodule

/* test/tb_top.sv */
// Testbench for the piecewise linear transfer function lookup unit
module tb_top;
    localparam int LatencyWait = 60;
    localparam int CycleLimit  = 1000000;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    pltl_pkg::req_t in_data;
    logic           out_valid;
    logic           out_ready;
    pltl_pkg::rsp_t out_data;
    logic           cfg_we;
    logic [1:0]     cfg_index;
    logic [15:0]    cfg_data;

    piecewise_linear_transfer_lookup_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow state of the unit
    logic [15:0] range_low_q;
    logic [15:0] range_high_q;
    logic [8:0]  color_count_q;
    logic [8:0]  opacity_count_q;
    logic [15:0] color_tab [pltl_pkg::TableDepth][3];
    logic [15:0] opacity_tab [pltl_pkg::TableDepth];

    pltl_pkg::req_t pending_reqs [$];
    pltl_pkg::rsp_t expected_colors [$];
    int     errors;
    int     cycles;
    logic   req_taken;
    int     in_gap;
    int     out_stall;
    logic   no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic locate(input logic [15:0] s, input int n,
                          output int lo, output int hi, output longint frac);
        longint pos;
        if (s <= range_low_q)
        begin
            lo = 0; hi = 0; frac = 0;
        end
        else if (s >= range_high_q)
        begin
            lo = n - 1; hi = n - 1; frac = 0;
        end
        else
        begin
            pos = ((longint'(s - range_low_q) * (n - 1)) << pltl_pkg::FracBits) /
                  longint'(range_high_q - range_low_q);
            lo = int'(pos >> pltl_pkg::FracBits);
            if (lo > n - 1)
                lo = n - 1;
            hi = (lo + 1 < n) ? lo + 1 : n - 1;
            frac = pos & ((64'd1 << pltl_pkg::FracBits) - 1);
        end
    endtask

    function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b, longint f);
        longint sum;
        sum = longint'(a) * ((64'd1 << pltl_pkg::FracBits) - f) + longint'(b) * f;
        return 16'(sum >> pltl_pkg::FracBits);
    endfunction

    task automatic apply_request(input pltl_pkg::req_t r);
        pltl_pkg::rsp_t res;
        int     n;
        int     lo;
        int     hi;
        longint f;
        if (r.func == pltl_pkg::FUNC_WR_COLOR)
        begin
            color_tab[r.entry_index][0] = r.red_in;
            color_tab[r.entry_index][1] = r.green_in;
            color_tab[r.entry_index][2] = r.blue_in;
        end
        else if (r.func == pltl_pkg::FUNC_WR_OPACITY)
            opacity_tab[r.entry_index] = r.alpha_in;
        else if (r.func == pltl_pkg::FUNC_LOOKUP)
        begin
            if (r.sample_invalid)
                res = '0;
            else
            begin
                n = (color_count_q > pltl_pkg::TableDepth) ?
                    pltl_pkg::TableDepth : color_count_q;
                if (n == 0)
                begin
                    res.red_out = '1; res.green_out = '1; res.blue_out = '1;
                end
                else
                begin
                    locate(r.sample, n, lo, hi, f);
                    res.red_out   = blend(color_tab[lo][0], color_tab[hi][0], f);
                    res.green_out = blend(color_tab[lo][1], color_tab[hi][1], f);
                    res.blue_out  = blend(color_tab[lo][2], color_tab[hi][2], f);
                end
                n = (opacity_count_q > pltl_pkg::TableDepth) ?
                    pltl_pkg::TableDepth : opacity_count_q;
                if (n == 0)
                    res.alpha_out = '1;
                else
                begin
                    locate(r.sample, n, lo, hi, f);
                    res.alpha_out = blend(opacity_tab[lo], opacity_tab[hi], f);
                end
            end
            expected_colors.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            out_ready <= 1'b0;
            in_gap    <= 0;
            out_stall <= 0;
        end
        else
        begin
            if (!in_valid || req_taken)
            begin
                if (in_gap > 0 || pending_reqs.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (in_gap > 0)
                        in_gap <= in_gap - 1;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_reqs.pop_front();
                    in_gap   <= idle_len();
                end
            end
            if (out_stall > 0)
            begin
                out_ready <= 1'b0;
                out_stall <= out_stall - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                out_stall <= idle_len();
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            cycles <= cycles + 1;
            req_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
                apply_request(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %h", out_data));
                end
                else
                begin
                    pltl_pkg::rsp_t e;
                    e = expected_colors.pop_front();
                    if (out_data.red_out !== e.red_out)
                        report_mismatch($sformatf("red expected %h got %h",
                                                  e.red_out, out_data.red_out));
                    if (out_data.green_out !== e.green_out)
                        report_mismatch($sformatf("green expected %h got %h",
                                                  e.green_out, out_data.green_out));
                    if (out_data.blue_out !== e.blue_out)
                        report_mismatch($sformatf("blue expected %h got %h",
                                                  e.blue_out, out_data.blue_out));
                    if (out_data.alpha_out !== e.alpha_out)
                        report_mismatch($sformatf("alpha expected %h got %h",
                                                  e.alpha_out, out_data.alpha_out));
                end
            end
            if (cycles >= CycleLimit)
            begin
                $display("** piecewise_linear_transfer_lookup_unit: FAILED **");
                $finish;
            end
        end
    end

    function automatic pltl_pkg::req_t random_req();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return pltl_pkg::req_t'(raw[$bits(pltl_pkg::req_t)-1:0]);
    endfunction

    function automatic pltl_pkg::req_t lookup_req(logic [15:0] s, logic inv);
        pltl_pkg::req_t r;
        r = random_req();
        r.func = pltl_pkg::FUNC_LOOKUP;
        r.sample = s;
        r.sample_invalid = inv;
        return r;
    endfunction

    function automatic pltl_pkg::req_t write_req(logic [1:0] f, logic [7:0] ix);
        pltl_pkg::req_t r;
        r = random_req();
        r.func = f;
        r.entry_index = ix;
        return r;
    endfunction

    function automatic logic [15:0] pick_sample();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'h0000;
        if (k == 1)
            return 16'hffff;
        if (k == 2)
            return range_low_q + 16'($urandom_range(0, 2)) - 16'd1;
        if (k == 3)
            return range_high_q + 16'($urandom_range(0, 2)) - 16'd1;
        if (k < 7 && range_high_q > range_low_q)
            return 16'($urandom_range(range_low_q, range_high_q));
        return 16'($urandom);
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_valid || expected_colors.size() != 0)
            @(posedge clk);
        repeat (LatencyWait) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            pltl_pkg::CFG_RANGE_LOW:     range_low_q     = val;
            pltl_pkg::CFG_RANGE_HIGH:    range_high_q    = val;
            pltl_pkg::CFG_COLOR_COUNT:   color_count_q   = val[8:0];
            pltl_pkg::CFG_OPACITY_COUNT: opacity_count_q = val[8:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_phase(input logic [15:0] lo_v, input logic [15:0] hi_v,
                             input logic [15:0] cc, input logic [15:0] oc);
        wait_idle();
        write_cfg(pltl_pkg::CFG_RANGE_LOW, lo_v);
        write_cfg(pltl_pkg::CFG_RANGE_HIGH, hi_v);
        write_cfg(pltl_pkg::CFG_COLOR_COUNT, cc);
        write_cfg(pltl_pkg::CFG_OPACITY_COUNT, oc);
        no_idle = ($urandom_range(0, 3) == 0);
    endtask

    task automatic random_requests(input int count);
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 75)
                pending_reqs.push_back(lookup_req(pick_sample(), $urandom_range(0, 7) == 0));
            else if (k < 85)
                pending_reqs.push_back(write_req(pltl_pkg::FUNC_WR_COLOR, 8'($urandom)));
            else if (k < 95)
                pending_reqs.push_back(write_req(pltl_pkg::FUNC_WR_OPACITY, 8'($urandom)));
            else
                pending_reqs.push_back(write_req(pltl_pkg::FUNC_IGNORED, 8'($urandom)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        no_idle = 1'b0;
        range_low_q = 16'h0000;
        range_high_q = 16'hffff;
        color_count_q = '0;
        opacity_count_q = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty tables: white and opaque, invalid samples black
        pending_reqs.push_back(lookup_req(16'h0000, 1'b0));
        pending_reqs.push_back(lookup_req(16'hffff, 1'b0));
        pending_reqs.push_back(lookup_req(16'h1234, 1'b1));
        pending_reqs.push_back(write_req(pltl_pkg::FUNC_IGNORED, 8'hff));
        pending_reqs.push_back(lookup_req(16'h8000, 1'b0));
        // load every entry of both tables
        for (int i = 0; i < pltl_pkg::TableDepth; i++)
        begin
            pending_reqs.push_back(write_req(pltl_pkg::FUNC_WR_COLOR, 8'(i)));
            pending_reqs.push_back(write_req(pltl_pkg::FUNC_WR_OPACITY, 8'(i)));
        end
        pending_reqs.push_back(write_req(pltl_pkg::FUNC_WR_COLOR, 8'hff));

        set_phase(16'h0000, 16'hffff, 16'd256, 16'd256);
        pending_reqs.push_back(lookup_req(16'h0000, 1'b0));
        pending_reqs.push_back(lookup_req(16'hffff, 1'b0));
        pending_reqs.push_back(lookup_req(16'h0001, 1'b0));
        pending_reqs.push_back(lookup_req(16'hfffe, 1'b0));
        pending_reqs.push_back(lookup_req(16'h7fff, 1'b0));
        pending_reqs.push_back(lookup_req(16'hffff, 1'b1));
        random_requests(150);

        set_phase(16'h0000, 16'hffff, 16'd1, 16'd1);
        random_requests(100);
        set_phase(16'd1000, 16'd2000, 16'd2, 16'd3);
        random_requests(150);
        set_phase(16'hffff, 16'h0000, 16'd5, 16'd7);
        random_requests(100);
        set_phase(16'h0000, 16'h0001, 16'd511, 16'd17);
        random_requests(100);
        set_phase(16'd300, 16'd300, 16'd100, 16'd0);
        random_requests(100);
        set_phase(16'hfffe, 16'hffff, 16'd0, 16'd256);
        random_requests(100);
        for (int p = 0; p < 8; p++)
        begin
            set_phase(16'($urandom), 16'($urandom), 16'($urandom_range(0, 511)),
                      16'($urandom_range(0, 511)));
            random_requests(120);
        end

        while (pending_reqs.size() != 0 || in_valid || expected_colors.size() != 0)
            @(posedge clk);
        repeat (LatencyWait) @(posedge clk);
        if (errors == 0)
            $display("** piecewise_linear_transfer_lookup_unit: PASSED **");
        else
            $display("** piecewise_linear_transfer_lookup_unit: FAILED **");
        $finish;
    end
endmodule
